// File: hw/rtl/vns_pkg.sv
// Shared types, constants and register codes for the nearest-seed colour block.
// Used by vns_dist, voronoi_nearest_seed_color_top and its testbench.
package vns_pkg;

  localparam int MAX_SEEDS_DEF  = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;

  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 7;
  localparam int COLOR_W    = 8;
  localparam int SEED_IDX_W = 6;
  localparam int FRAC_W     = 16;
  localparam int PIX_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [SIZE_W-1:0]  WIDTH_RST  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = SIZE_W'(256);
  localparam logic [COUNT_W-1:0] COUNT_RST  = COUNT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COUNT  = 2'd2,
    CFG_GRAY   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_SEED_WR = 1'b0,
    FUNC_PIXEL   = 1'b1
  } func_t;

  typedef struct packed {
    func_t                  func;
    logic [SEED_IDX_W-1:0]  seed_index;
    logic [FRAC_W-1:0]      seed_x_frac;
    logic [FRAC_W-1:0]      seed_y_frac;
    logic [COLOR_W-1:0]     seed_red;
    logic [COLOR_W-1:0]     seed_green;
    logic [COLOR_W-1:0]     seed_blue;
    logic [PIX_W-1:0]       pixel_x;
    logic [PIX_W-1:0]       pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]    out_red;
    logic [COLOR_W-1:0]    out_green;
    logic [COLOR_W-1:0]    out_blue;
    logic [SEED_IDX_W-1:0] nearest_seed;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Travels alongside each seed through the distance pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tag_t;

endpackage

// File: hw/rtl/vns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/vns_dist.sv
// Squared-distance pipeline: scale seed position, take differences, square.
// Depends on vns_pkg.
module vns_dist
  import vns_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AW         = 6,
  parameter int SW         = FRAC_BITS + SIZE_W,
  parameter int PW         = FRAC_BITS + COORD_BITS,
  parameter int DW         = (SW > PW) ? SW : PW,
  parameter int SQW        = 2 * DW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tag_t                  tag_in,
  input  logic [AW-1:0]         idx_in,
  input  logic [FRAC_BITS-1:0]  x_frac,
  input  logic [FRAC_BITS-1:0]  y_frac,
  input  rgb_t                  rgb_in,
  input  logic [SIZE_W-1:0]     width,
  input  logic [SIZE_W-1:0]     height,
  input  logic [COORD_BITS-1:0] pix_x,
  input  logic [COORD_BITS-1:0] pix_y,
  output tag_t                  tag_out,
  output logic [AW-1:0]         idx_out,
  output rgb_t                  rgb_out,
  output logic [SQW-1:0]        dx2,
  output logic [SQW-1:0]        dy2
);

  tag_t          tag1_r, tag2_r, tag3_r;
  logic [AW-1:0] idx1_r, idx2_r, idx3_r;
  rgb_t          rgb1_r, rgb2_r, rgb3_r;
  logic [SW-1:0] sx_r, sy_r;
  logic [DW-1:0] dx_r, dy_r;
  logic [DW-1:0] px, py, sxe, sye;
  logic [SQW-1:0] dx2_r, dy2_r;

  assign px  = DW'(pix_x) << FRAC_BITS;
  assign py  = DW'(pix_y) << FRAC_BITS;
  assign sxe = DW'(sx_r);
  assign sye = DW'(sy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= idx_in;
    rgb1_r <= rgb_in;
    sx_r   <= SW'(x_frac) * SW'(width);
    sy_r   <= SW'(y_frac) * SW'(height);

    idx2_r <= idx1_r;
    rgb2_r <= rgb1_r;
    dx_r   <= (px >= sxe) ? (px - sxe) : (sxe - px);
    dy_r   <= (py >= sye) ? (py - sye) : (sye - py);

    idx3_r <= idx2_r;
    rgb3_r <= rgb2_r;
    dx2_r  <= SQW'(dx_r) * SQW'(dx_r);
    dy2_r  <= SQW'(dy_r) * SQW'(dy_r);
  end

  assign tag_out = tag3_r;
  assign idx_out = idx3_r;
  assign rgb_out = rgb3_r;
  assign dx2     = dx2_r;
  assign dy2     = dy2_r;

endmodule

// File: hw/rtl/voronoi_nearest_seed_color_top.sv
// Nearest-seed Voronoi colour block: seed table in RAM, one seed scanned per cycle.
// Depends on vns_pkg, vns_ram and vns_dist.
//
//   channel  ports                         handshake
//   input    start, busy, in_item          taken when start & !busy
//   result   out_strobe, out_item          one cycle, no back-pressure
//   config   cfg_we, cfg_index, cfg_wdata  written when cfg_we
//
// A seed write goes into the table on acceptance and leaves busy low.
// A pixel with nonzero count and size scans seed_count seeds (at most MAX_SEEDS) through
// the single RAM read port feeding one distance pipeline, one seed a cycle; the strobe is registered.
// busy falls in the cycle the result is shown. Synchronous active-low reset;
// the seed table is not cleared and needs no clearing pass.
module voronoi_nearest_seed_color_top
  import vns_pkg::*;
#(
  parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW  = $clog2(MAX_SEEDS + 1);
  localparam int EW  = 2 * FRAC_BITS + 3 * COLOR_W;
  localparam int SW  = FRAC_BITS + SIZE_W;
  localparam int PW  = FRAC_BITS + COORD_BITS;
  localparam int DW  = (SW > PW) ? SW : PW;
  localparam int SQW = 2 * DW;
  localparam int DSW = SQW + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  width_r, height_r;
  logic [COUNT_W-1:0] count_r;
  logic               gray_r;

  logic [COORD_BITS-1:0] pix_x_r, pix_y_r;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  tag_t                  tag0_r, tag0_nxt;
  logic [AW-1:0]         idx0_r;

  logic [CW-1:0] n_sat;
  logic          accept, pix_go, scan_last;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  tag_t           tag3;
  logic [AW-1:0]  idx3;
  rgb_t           rgb3;
  logic [SQW-1:0] dx2, dy2;

  logic [DSW-1:0] dist_sum, best_dist_r, best_dist_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  rgb_t           best_rgb_r, best_rgb_nxt;
  logic           take;

  logic      out_strobe_r;
  out_item_t out_item_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      count_r  <= COUNT_RST;
      gray_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:  width_r  <= SIZE_W'(cfg_wdata);
        CFG_HEIGHT: height_r <= SIZE_W'(cfg_wdata);
        CFG_COUNT:  count_r  <= COUNT_W'(cfg_wdata);
        CFG_GRAY:   gray_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(count_r) > MAX_SEEDS) begin
      n_sat = CW'(MAX_SEEDS);
    end else begin
      n_sat = CW'(count_r);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign pix_go    = accept && (in_item.func == FUNC_PIXEL) && (n_sat != '0)
                     && (width_r != '0) && (height_r != '0);
  assign scan_last = ((CW'(cnt_r) + CW'(1)) == n_sat);

  // Seed writes go straight to the table
  assign ram_we    = accept && (in_item.func == FUNC_SEED_WR)
                     && (32'(in_item.seed_index) < MAX_SEEDS);
  assign ram_waddr = AW'(in_item.seed_index);
  assign ram_wdata = {FRAC_BITS'(in_item.seed_x_frac), FRAC_BITS'(in_item.seed_y_frac),
                      in_item.seed_red, in_item.seed_green, in_item.seed_blue};
  assign ram_re    = (state_r == ST_SCAN);

  vns_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEEDS),
    .AW    (AW)
  ) u_seed_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // Scan sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tag0_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (pix_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tag0_nxt.vld   = 1'b1;
        tag0_nxt.first = (cnt_r == '0);
        tag0_nxt.last  = scan_last;
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (tag3.vld && tag3.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      tag0_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tag0_r  <= tag0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx0_r <= cnt_r;
    if (pix_go) begin
      pix_x_r <= COORD_BITS'(in_item.pixel_x);
      pix_y_r <= COORD_BITS'(in_item.pixel_y);
    end
  end

  vns_dist #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .SW         (SW),
    .PW         (PW),
    .DW         (DW),
    .SQW        (SQW)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag0_r),
    .idx_in  (idx0_r),
    .x_frac  (ram_rdata[EW-1 -: FRAC_BITS]),
    .y_frac  (ram_rdata[EW-FRAC_BITS-1 -: FRAC_BITS]),
    .rgb_in  (rgb_t'(ram_rdata[3*COLOR_W-1:0])),
    .width   (width_r),
    .height  (height_r),
    .pix_x   (pix_x_r),
    .pix_y   (pix_y_r),
    .tag_out (tag3),
    .idx_out (idx3),
    .rgb_out (rgb3),
    .dx2     (dx2),
    .dy2     (dy2)
  );

  // Compare: strictly smaller replaces, so the earlier seed keeps a tie
  assign dist_sum = DSW'(dx2) + DSW'(dy2);
  assign take     = tag3.first || (dist_sum < best_dist_r);

  always_comb begin
    if (take) begin
      best_dist_nxt = dist_sum;
      best_idx_nxt  = idx3;
      best_rgb_nxt  = rgb3;
    end else begin
      best_dist_nxt = best_dist_r;
      best_idx_nxt  = best_idx_r;
      best_rgb_nxt  = best_rgb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag3.vld) begin
      best_dist_r <= best_dist_nxt;
      best_idx_r  <= best_idx_nxt;
      best_rgb_r  <= best_rgb_nxt;
    end
    if (tag3.vld && tag3.last) begin
      out_item_r.out_red      <= best_rgb_nxt.red;
      out_item_r.out_green    <= gray_r ? '0 : best_rgb_nxt.green;
      out_item_r.out_blue     <= gray_r ? '0 : best_rgb_nxt.blue;
      out_item_r.nearest_seed <= SEED_IDX_W'(best_idx_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tag3.vld && tag3.last;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_strobe_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_DRAIN))
    else $error("result strobe without a finished scan");

  a_pipe_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tag3.vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance pipeline active while idle");

  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && $past(state_r == ST_SCAN)) |-> (cnt_r == $past(cnt_r) + AW'(1)))
    else $error("scan counter skipped or held");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> !ram_we)
    else $error("seed write during a pixel scan");

endmodule

// File: verif/tb_voronoi_nearest_seed_color_top.sv
// Testbench for voronoi_nearest_seed_color_top: seed writes and pixel renders are checked
// against a nearest-seed predictor that is updated on every accepted item and register write.
// Depends on vns_pkg and the RTL of voronoi_nearest_seed_color_top.
`timescale 1ns / 100ps

module tb_voronoi_nearest_seed_color_top;
  import vns_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = MAX_SEEDS_DEF + 16;
  localparam int unsigned PHASE_ITEMS   = 115;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_item_t           seed_copy [MAX_SEEDS_DEF];
  logic [SIZE_W-1:0]  img_w     = WIDTH_RST;
  logic [SIZE_W-1:0]  img_h     = HEIGHT_RST;
  logic [COUNT_W-1:0] seed_cnt  = COUNT_RST;
  logic               gray_mode = 1'b0;

  in_item_t                 item_q [$];
  out_item_t                colour_q [$];
  logic [MAX_SEEDS_DEF-1:0] gen_written   = '0;
  int unsigned              send_idle_pct = 0;
  int unsigned              errors        = 0;
  int unsigned              cycles        = 0;
  logic                     nxt_start;
  in_item_t                 nxt_item;

  voronoi_nearest_seed_color_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 100) begin
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  function automatic logic [58:0] dist_sq(input in_item_t s, input logic [PIX_W-1:0] px,
                                          input logic [PIX_W-1:0] py);
    logic [28:0] sx, sy, qx, qy, dx, dy;
    sx = 29'(s.seed_x_frac) * 29'(img_w);
    sy = 29'(s.seed_y_frac) * 29'(img_h);
    qx = 29'({px, {FRAC_W{1'b0}}});
    qy = 29'({py, {FRAC_W{1'b0}}});
    dx = (qx >= sx) ? qx - sx : sx - qx;
    dy = (qy >= sy) ? qy - sy : sy - qy;
    return 59'(dx) * 59'(dx) + 59'(dy) * 59'(dy);
  endfunction

  task automatic render_item(input in_item_t it);
    int unsigned n, best;
    logic [58:0] best_d, d;
    out_item_t   res;
    n = (seed_cnt > MAX_SEEDS_DEF) ? MAX_SEEDS_DEF : 32'(seed_cnt);
    if (it.func == FUNC_SEED_WR) begin
      seed_copy[it.seed_index] = it;
    end else if (n != 0 && img_w != 0 && img_h != 0) begin
      best   = 0;
      best_d = dist_sq(seed_copy[0], it.pixel_x, it.pixel_y);
      for (int unsigned i = 1; i < n; i++) begin
        d = dist_sq(seed_copy[i], it.pixel_x, it.pixel_y);
        if (d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      res.out_red      = seed_copy[best].seed_red;
      res.out_green    = gray_mode ? '0 : seed_copy[best].seed_green;
      res.out_blue     = gray_mode ? '0 : seed_copy[best].seed_blue;
      res.nearest_seed = SEED_IDX_W'(best);
      colour_q.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_item  = in_item;
      if (start && !busy) begin
        render_item(in_item);
        nxt_start = 1'b0;
      end
      if (!nxt_start && item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_item  = item_q.pop_front();
        nxt_start = 1'b1;
      end
      start   <= nxt_start;
      in_item <= nxt_item;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (colour_q.size() == 0) begin
        report_mismatch("result with none expected", 32'(out_item), '0);
      end else begin
        out_item_t want;
        want = colour_q.pop_front();
        if (out_item.out_red !== want.out_red)
          report_mismatch("out_red", 32'(out_item.out_red), 32'(want.out_red));
        if (out_item.out_green !== want.out_green)
          report_mismatch("out_green", 32'(out_item.out_green), 32'(want.out_green));
        if (out_item.out_blue !== want.out_blue)
          report_mismatch("out_blue", 32'(out_item.out_blue), 32'(want.out_blue));
        if (out_item.nearest_seed !== want.nearest_seed)
          report_mismatch("nearest_seed", 32'(out_item.nearest_seed),
                          32'(want.nearest_seed));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("voronoi_nearest_seed_color_top: mismatch");
      $finish;
    end
  end

  function automatic in_item_t filler();
    in_item_t it;
    it.func        = FUNC_PIXEL;
    it.seed_index  = SEED_IDX_W'($urandom);
    it.seed_x_frac = FRAC_W'($urandom);
    it.seed_y_frac = FRAC_W'($urandom);
    it.seed_red    = COLOR_W'($urandom);
    it.seed_green  = COLOR_W'($urandom);
    it.seed_blue   = COLOR_W'($urandom);
    it.pixel_x     = PIX_W'($urandom);
    it.pixel_y     = PIX_W'($urandom);
    return it;
  endfunction

  task automatic queue_seed(input logic [SEED_IDX_W-1:0] idx, input logic [FRAC_W-1:0] x,
                            input logic [FRAC_W-1:0] y, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    in_item_t it;
    it             = filler();
    it.func        = FUNC_SEED_WR;
    it.seed_index  = idx;
    it.seed_x_frac = x;
    it.seed_y_frac = y;
    it.seed_red    = r;
    it.seed_green  = g;
    it.seed_blue   = b;
    gen_written[idx] = 1'b1;
    item_q.push_back(it);
  endtask

  task automatic queue_random_seed(input logic [SEED_IDX_W-1:0] idx);
    queue_seed(idx, FRAC_W'($urandom), FRAC_W'($urandom), COLOR_W'($urandom),
               COLOR_W'($urandom), COLOR_W'($urandom));
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    in_item_t it;
    it         = filler();
    it.pixel_x = x;
    it.pixel_y = y;
    item_q.push_back(it);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH:  img_w     = SIZE_W'(val);
      CFG_HEIGHT: img_h     = SIZE_W'(val);
      CFG_COUNT:  seed_cnt  = COUNT_W'(val);
      CFG_GRAY:   gray_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (item_q.size() != 0 || start || colour_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int unsigned w, input int unsigned h, input int unsigned c,
                              input int unsigned g, input int unsigned idle_pct);
    int unsigned n, xl, yl;
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_COUNT, c);
    write_reg(CFG_GRAY, g);
    send_idle_pct = idle_pct;
    n  = (seed_cnt > MAX_SEEDS_DEF) ? MAX_SEEDS_DEF : seed_cnt;
    xl = (img_w == 0) ? 0 : ((img_w > 4096) ? 4095 : img_w - 1);
    yl = (img_h == 0) ? 0 : ((img_h > 4096) ? 4095 : img_h - 1);
    // fill every scanned entry before the first pixel
    for (int unsigned i = 0; i < n; i++) begin
      if (!gen_written[i]) queue_random_seed(SEED_IDX_W'(i));
    end
    for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
      if ($urandom_range(3) == 0) begin
        queue_random_seed(SEED_IDX_W'($urandom_range(MAX_SEEDS_DEF - 1)));
      end else if ($urandom_range(1) == 0) begin
        queue_pixel(PIX_W'($urandom_range(xl)), PIX_W'($urandom_range(yl)));
      end else begin
        queue_pixel(PIX_W'($urandom), PIX_W'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 23;

    // reset settings: one seed, pixels inside and outside the image
    queue_seed(0, 16'h0000, 16'h0000, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'hFFF, 12'hFFF);
    queue_seed(0, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
    queue_seed(63, 16'hFFFF, 16'h0000, 8'hAA, 8'h55, 8'h12);
    queue_pixel(12'd255, 12'd255);
    queue_pixel(12'd0, 12'hFFF);
    drain();

    // gray mode, extreme sizes and two seeds at one spot
    write_reg(CFG_COUNT, 4);
    write_reg(CFG_GRAY, 1);
    write_reg(CFG_WIDTH, 4096);
    write_reg(CFG_HEIGHT, 1);
    queue_seed(1, 16'h8000, 16'h8000, 8'h11, 8'h22, 8'h33);
    queue_seed(2, 16'h8000, 16'h8000, 8'h44, 8'h55, 8'h66);
    queue_seed(3, 16'h0000, 16'hFFFF, 8'h77, 8'h88, 8'h99);
    queue_pixel(12'd2048, 12'd0);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'hFFF, 12'hFFF);
    drain();

    // zero count, zero width and zero height give no result
    write_reg(CFG_COUNT, 0);
    queue_pixel(12'd1, 12'd1);
    drain();
    write_reg(CFG_COUNT, 4);
    write_reg(CFG_WIDTH, 0);
    queue_pixel(12'd5, 12'd5);
    drain();
    write_reg(CFG_WIDTH, 300);
    write_reg(CFG_HEIGHT, 0);
    queue_pixel(12'd7, 12'd7);
    drain();

    random_phase(256, 256, 8, 0, 23);
    random_phase(1, 1, 64, 1, 23);
    random_phase(4096, 4096, 100, 0, 23);
    random_phase(8191, 8191, 127, 1, 70);
    random_phase(640, 480, 16, 0, 70);
    random_phase(1, 4096, 2, 1, 70);
    random_phase($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(64, 1),
                 $urandom_range(1), 0);
    random_phase(4096, 1, 64, 0, 0);
    random_phase($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(64, 1),
                 $urandom_range(1), 0);

    if (errors == 0) begin
      $display("voronoi_nearest_seed_color_top: match");
    end else begin
      $display("voronoi_nearest_seed_color_top: mismatch");
    end
    $finish;
  end

endmodule
